/* rtl/core/ter_pkg.sv */
// Shared constants for the timestamped ring expiry emitter.
// Used by the expiry cell, the divider and the top level; no dependencies.
`default_nettype none

package ter_pkg;

	localparam int CAPACITY_DEF = 256;

	localparam int TIME_W    = 32;
	localparam int ELAPSED_W = 20;
	localparam int PERIOD_W  = 24;
	// accumulator after adding elapsed stays at or below period + 2^20 < 2^25
	localparam int ACC_W     = 25;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [TIME_W-1:0]   LIFETIME_RST = 32'd5000000;
	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 24'd10000;

	// register indexes, taken from paddr[2]
	localparam logic [0:0] REG_LIFETIME = 1'b0;
	localparam logic [0:0] REG_PERIOD   = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/ter_cell.sv */
// One ring slot: holds a stamp, tests it for expiry as the count wave passes.
// Depends on ter_pkg for time widths.
`default_nettype none

module ter_cell #(
	parameter int CAPACITY = ter_pkg::CAPACITY_DEF,
	parameter int IDX = 0,
	localparam int IW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [ter_pkg::TIME_W-1:0] now,
	input  wire logic [ter_pkg::TIME_W-1:0] lifetime,
	input  wire logic [IW-1:0]             head,
	input  wire logic [CW-1:0]             live,
	input  wire logic [IW-1:0]             tail,
	input  wire logic [CW-1:0]             wcount,
	input  wire logic                      wr_en,
	input  wire logic                      tok_in,
	input  wire logic [CW-1:0]             cnt_in,
	output logic                           tok_out,
	output logic [CW-1:0]                  cnt_out
);

	localparam logic [CW-1:0] POS  = CW'(IDX);
	localparam logic [CW-1:0] CAPV = CW'(CAPACITY);

	logic [ter_pkg::TIME_W-1:0] stamp_q;
	logic                       tok_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              hd, tl, off_live, off_wr;
	logic [ter_pkg::TIME_W-1:0] age;
	logic                       hit;

	always_comb begin
		hd = CW'(head);
		tl = CW'(tail);
		// distance from head and from tail, modulo the ring size
		off_live = (POS >= hd) ? POS - hd : POS + CAPV - hd;
		off_wr   = (POS >= tl) ? POS - tl : POS + CAPV - tl;
		age = now - stamp_q;
		hit = (off_live < live) && (age >= lifetime);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			tok_q <= tok_in;
			if (tok_in) begin
				cnt_q <= cnt_in + CW'(hit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (off_wr < wcount)) begin
			stamp_q <= now;
		end
	end

	assign tok_out = tok_q;
	assign cnt_out = cnt_q;

endmodule

`default_nettype wire

/* rtl/core/ter_div.sv */
// Restoring divider, one quotient bit per cycle, for whole emit periods.
// Depends on ter_pkg for the accumulator and period widths.
`default_nettype none

module ter_div #(
	parameter int NW = ter_pkg::ACC_W,
	parameter int DW = ter_pkg::PERIOD_W,
	localparam int SW = $clog2(NW)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic [NW-1:0]      quotient,
	output logic [DW-1:0]      remainder
);

	logic          busy_q;
	logic [SW-1:0] step_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + SW'(1);
			if (step_q == SW'(NW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			// partial remainder stays below divisor, so DW bits hold it
			rem_q <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* rtl/core/timestamped_ring_expiry_emitter.sv */
// Top level of the timestamped ring expiry emitter: control, registers, cell row.
// Depends on ter_pkg, ter_cell and ter_div.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  elapsed[19:0], now[31:0]
//   out      out_valid/out_ready  alive_count, head_index, tail_index, retired,
//                                 emitted, blocked
//   cfg      APB psel/penable     paddr[2:0], pwdata/prdata[31:0], pready tied high
//
// Per word, a count token walks the row of CAPACITY cells one cell a cycle,
// while the divider finds the number of whole periods one bit a cycle. Reset
// clears the pointers, live count and accumulator; ring stamps are not cleared.
// A word is taken only while the block is idle; a finished result waits in the
// output register and does not block the next word until that word's result is
// ready.
`default_nettype none

module timestamped_ring_expiry_emitter #(
	parameter int CAPACITY = ter_pkg::CAPACITY_DEF,
	localparam int IW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ter_pkg::ELAPSED_W-1:0] elapsed,
	input  wire logic [ter_pkg::TIME_W-1:0]    now,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [CW-1:0]                      alive_count,
	output logic [IW-1:0]                      head_index,
	output logic [IW-1:0]                      tail_index,
	output logic [CW-1:0]                      retired,
	output logic [CW-1:0]                      emitted,
	output logic                               blocked,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ter_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [ter_pkg::DATA_W-1:0]    pwdata,
	output logic [ter_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);

	localparam int TW = ter_pkg::TIME_W;
	localparam int PW = ter_pkg::PERIOD_W;
	localparam int AW = ter_pkg::ACC_W;
	localparam logic [CW:0]   CAP_E = (CW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAPV  = CW'(CAPACITY);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_TALLY  = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0]    state_q;
	logic [TW-1:0] lifetime_q;
	logic [PW-1:0] period_q;
	logic [TW-1:0] now_q;
	logic [AW-1:0] acc_sum_q;
	logic [PW-1:0] acc_q;
	logic [IW-1:0] head_q, tail_q;
	logic [CW-1:0] live_q, emit_q, expired_q;
	logic          blocked_q, go_q, wave_q;
	logic          out_valid_q;
	logic [CW-1:0] alive_out_q, retired_out_q, emitted_out_q;
	logic [IW-1:0] head_out_q, tail_out_q;
	logic          blocked_out_q;

	logic          accept, cfg_wr, out_free, wr_en;
	logic [0:0]    reg_idx;
	logic [AW-1:0] dividend;
	logic [PW-1:0] divisor;
	logic          div_busy;
	logic [AW-1:0] n_per;
	logic [PW-1:0] div_rem;
	logic [CW:0]   hsum, tsum;
	logic [CW-1:0] expired, live_mid, room, emit_nx;
	logic [IW-1:0] head_nx, tail_nx;

	logic          tok [0:CAPACITY];
	logic [CW-1:0] cnt [0:CAPACITY];

	// configuration port
	assign reg_idx = paddr[ter_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_idx)
			ter_pkg::REG_LIFETIME: prdata = lifetime_q;
			ter_pkg::REG_PERIOD:   prdata = ter_pkg::DATA_W'(period_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= ter_pkg::LIFETIME_RST;
			period_q   <= ter_pkg::PERIOD_RST;
		end else if (cfg_wr) begin
			if (reg_idx == ter_pkg::REG_LIFETIME) begin
				lifetime_q <= pwdata[TW-1:0];
			end else begin
				period_q <= pwdata[PW-1:0];
			end
		end
	end

	// handshakes
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign wr_en     = (state_q == ST_COMMIT) && out_free;

	// count token enters the row in the cycle after the word is taken
	assign tok[0] = go_q;
	assign cnt[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ter_cell #(.CAPACITY(CAPACITY), .IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.now      (now_q),
			.lifetime (lifetime_q),
			.head     (head_q),
			.live     (live_q),
			.tail     (tail_q),
			.wcount   (emit_q),
			.wr_en    (wr_en),
			.tok_in   (tok[i]),
			.cnt_in   (cnt[i]),
			.tok_out  (tok[i+1]),
			.cnt_out  (cnt[i+1])
		);
	end

	assign dividend = (acc_sum_q == '0) ? '0 : acc_sum_q - AW'(1);
	assign divisor  = (period_q == '0) ? PW'(1) : period_q;

	ter_div #(.NW(AW), .DW(PW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (go_q),
		.dividend  (dividend),
		.divisor   (divisor),
		.busy      (div_busy),
		.quotient  (n_per),
		.remainder (div_rem)
	);

	// retire from head, then fit the periods into the free room
	always_comb begin
		expired  = cnt[CAPACITY];
		hsum     = (CW+1)'(head_q) + (CW+1)'(expired);
		head_nx  = (hsum >= CAP_E) ? IW'(hsum - CAP_E) : IW'(hsum);
		live_mid = live_q - expired;
		room     = CAPV - live_mid;
		emit_nx  = (n_per < AW'(room)) ? CW'(n_per) : room;
		tsum     = (CW+1)'(tail_q) + (CW+1)'(emit_q);
		tail_nx  = (tsum >= CAP_E) ? IW'(tsum - CAP_E) : IW'(tsum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			wave_q      <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			live_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= accept;
			// load a new word, or drop the old one once taken
			if (wr_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wave_q  <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tok[CAPACITY]) begin
						wave_q <= 1'b1;
					end
					if (wave_q && !div_busy && !go_q) begin
						state_q <= ST_TALLY;
					end
				end
				ST_TALLY: begin
					head_q  <= head_nx;
					live_q  <= live_mid;
					acc_q   <= (acc_sum_q == '0) ? '0 : div_rem + PW'(1);
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					// hold until the output register is free
					if (out_free) begin
						tail_q  <= tail_nx;
						live_q  <= live_q + emit_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q     <= now;
			acc_sum_q <= AW'(acc_q) + AW'(elapsed);
		end
		if (state_q == ST_TALLY) begin
			expired_q <= expired;
			emit_q    <= emit_nx;
			blocked_q <= n_per > AW'(room);
		end
		if (wr_en) begin
			alive_out_q   <= live_q + emit_q;
			head_out_q    <= head_q;
			tail_out_q    <= tail_nx;
			retired_out_q <= expired_q;
			emitted_out_q <= emit_q;
			blocked_out_q <= blocked_q;
		end
	end

	assign alive_count = alive_out_q;
	assign head_index  = head_out_q;
	assign tail_index  = tail_out_q;
	assign retired     = retired_out_q;
	assign emitted     = emitted_out_q;
	assign blocked     = blocked_out_q;

endmodule

`default_nettype wire

/* verif/ring_tick_checker.sv */
// Checker for the timestamped ring expiry emitter: tracks register writes, predicts
// the result word of every accepted tick and compares it with the out channel.
// Depends on ter_pkg only.
module ring_tick_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [ter_pkg::ELAPSED_W-1:0] elapsed,
	input  logic [ter_pkg::TIME_W-1:0]    now,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [8:0]                    alive_count,
	input  logic [7:0]                    head_index,
	input  logic [7:0]                    tail_index,
	input  logic [8:0]                    retired,
	input  logic [8:0]                    emitted,
	input  logic                          blocked,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ter_pkg::ADDR_W-1:0]    paddr,
	input  logic [ter_pkg::DATA_W-1:0]    pwdata,
	input  logic [ter_pkg::DATA_W-1:0]    prdata,
	input  logic                          pready,
	output int unsigned                   mismatch_count,
	output int unsigned                   ticks_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = ter_pkg::CAPACITY_DEF;
	localparam int IW  = $clog2(CAP);
	localparam int CW  = $clog2(CAP + 1);

	typedef struct packed {
		logic [CW-1:0] alive;
		logic [IW-1:0] head;
		logic [IW-1:0] tail;
		logic [CW-1:0] retired;
		logic [CW-1:0] emitted;
		logic          blocked;
	} tick_result_t;

	logic [ter_pkg::TIME_W-1:0]   stamps [CAP];
	logic [IW-1:0]                head_ptr;
	logic [IW-1:0]                tail_ptr;
	logic [CW-1:0]                live_cnt;
	logic [31:0]                  acc;
	logic [ter_pkg::TIME_W-1:0]   lifetime_q;
	logic [ter_pkg::PERIOD_W-1:0] period_q;
	tick_result_t                 pending_ticks [$];
	int unsigned                  result_no;

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s is %0d, want %0d",
				result_no, name, got, want));
	endtask

	// Retire by count first, then drain the accumulator in whole periods.
	function automatic tick_result_t advance_ring(input logic [ter_pkg::ELAPSED_W-1:0] dt,
			input logic [ter_pkg::TIME_W-1:0] t_now);
		tick_result_t r;
		logic [31:0] per, whole, room, made, gone;
		int k;
		per = (period_q == '0) ? 32'd1 : 32'(period_q);
		gone = 0;
		for (k = 0; k < int'(live_cnt); k++) begin
			if (t_now - stamps[IW'(head_ptr + k)] >= lifetime_q)
				gone++;
		end
		head_ptr = head_ptr + IW'(gone);
		live_cnt = live_cnt - CW'(gone);
		acc = acc + 32'(dt);
		whole = (acc == 0) ? 32'd0 : (acc - 1) / per;
		acc = acc - whole * per;
		room = CAP - live_cnt;
		made = (whole < room) ? whole : room;
		for (k = 0; k < int'(made); k++) begin
			stamps[tail_ptr] = t_now;
			tail_ptr = tail_ptr + 1'b1;
		end
		live_cnt = live_cnt + CW'(made);
		r.alive   = live_cnt;
		r.head    = head_ptr;
		r.tail    = tail_ptr;
		r.retired = CW'(gone);
		r.emitted = CW'(made);
		r.blocked = whole > made;
		return r;
	endfunction

	initial begin
		mismatch_count  = 0;
		ticks_in_flight = 0;
		result_no       = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		logic [31:0] want_reg;
		if (!arst_n) begin
			head_ptr   = '0;
			tail_ptr   = '0;
			live_cnt   = '0;
			acc        = '0;
			lifetime_q = ter_pkg::LIFETIME_RST;
			period_q   = ter_pkg::PERIOD_RST;
			pending_ticks.delete();
			ticks_in_flight = 0;
		end else begin
			// compare before the new word is predicted
			if (out_valid && out_ready) begin
				result_no++;
				if (pending_ticks.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing pending",
						result_no));
				end else begin
					want = pending_ticks.pop_front();
					check_field("alive_count", 32'(alive_count), 32'(want.alive));
					check_field("head_index", 32'(head_index), 32'(want.head));
					check_field("tail_index", 32'(tail_index), 32'(want.tail));
					check_field("retired", 32'(retired), 32'(want.retired));
					check_field("emitted", 32'(emitted), 32'(want.emitted));
					check_field("blocked", 32'(blocked), 32'(want.blocked));
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == ter_pkg::REG_LIFETIME)
						lifetime_q = pwdata;
					else
						period_q = pwdata[ter_pkg::PERIOD_W-1:0];
				end else begin
					want_reg = (paddr[2] == ter_pkg::REG_LIFETIME) ? lifetime_q
						: 32'(period_q);
					if (prdata !== want_reg)
						report_mismatch($sformatf("register read at %0d is %0h, want %0h",
							paddr, prdata, want_reg));
				end
			end
			if (in_valid && in_ready)
				pending_ticks.push_back(advance_ring(elapsed, now));
			ticks_in_flight = pending_ticks.size();
		end
	end

endmodule

/* verif/testbench.sv */
// Top of the emitter testbench: clock, reset, tick and register stimulus, verdict.
// Depends on ter_pkg, the emitter RTL and ring_tick_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ELAPSED_W = ter_pkg::ELAPSED_W;
	localparam int TIME_W    = ter_pkg::TIME_W;
	localparam int PERIOD_W  = ter_pkg::PERIOD_W;
	localparam int ADDR_W    = ter_pkg::ADDR_W;
	localparam int DATA_W    = ter_pkg::DATA_W;

	localparam int HOLD_CYCLES = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [ELAPSED_W-1:0]  elapsed;
	logic [TIME_W-1:0]     now;
	logic                  out_valid;
	logic                  out_ready;
	logic [8:0]            alive_count;
	logic [7:0]            head_index;
	logic [7:0]            tail_index;
	logic [8:0]            retired;
	logic [8:0]            emitted;
	logic                  blocked;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [DATA_W-1:0]     pwdata;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	int unsigned           mismatch_count;
	int unsigned           ticks_in_flight;

	bit                    calm;
	bit                    stall_req;
	logic [TIME_W-1:0]     sim_now;

	timestamped_ring_expiry_emitter u_dut (.*);
	ring_tick_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("testbench failed");
		$finish;
	end

	// receiver: random back-pressure, plus one long hold on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 8);
		end
	end

	task automatic send_tick(input logic [ELAPSED_W-1:0] dt,
			input logic [TIME_W-1:0] t);
		while (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		elapsed  <= dt;
		now      <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// drop valid and hold until every word has come back
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		wait (ticks_in_flight == 0);
	endtask

	// write one register, then read it back
	task automatic write_register(input logic [0:0] idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [TIME_W-1:0] life,
			input logic [PERIOD_W-1:0] per);
		drain();
		write_register(ter_pkg::REG_LIFETIME, life);
		// upper bits of the period word are don't-care
		write_register(ter_pkg::REG_PERIOD, {8'($urandom), per});
	endtask

	function automatic logic [ELAPSED_W-1:0] pick_elapsed(input logic [PERIOD_W-1:0] per);
		int sel;
		logic [31:0] span;
		sel = $urandom_range(0, 9);
		span = (per == '0) ? 32'd3 : 32'(per) * 3;
		case (sel)
			0: return '0;
			1: return '1;
			2, 3: return ELAPSED_W'($urandom);
			4, 5: return ELAPSED_W'($urandom_range(0, 1023));
			default: return (span > 32'hFFFFF) ? ELAPSED_W'($urandom)
				: ELAPSED_W'($urandom_range(0, span));
		endcase
	endfunction

	task automatic random_tick(input logic [PERIOD_W-1:0] per);
		int pick;
		logic [ELAPSED_W-1:0] dt;
		pick = $urandom_range(0, 99);
		dt = pick_elapsed(per);
		if (pick < 80) begin
			sim_now = sim_now + dt;
			send_tick(dt, sim_now);
		end else if (pick < 90) begin
			// step back so that the newest stamps look ancient
			sim_now = sim_now - $urandom_range(0, 1 << 20);
			send_tick(dt, sim_now);
		end else begin
			send_tick(ELAPSED_W'($urandom), TIME_W'($urandom));
		end
	endtask

	task automatic run_phase(input int count, input logic [TIME_W-1:0] life,
			input logic [PERIOD_W-1:0] per);
		int i;
		set_registers(life, per);
		if ($urandom_range(0, 1) == 1)
			sim_now = $urandom;
		for (i = 0; i < count; i++)
			random_tick(per);
	endtask

	initial begin
		logic [TIME_W-1:0]   life;
		logic [PERIOD_W-1:0] per;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		elapsed   <= '0;
		now       <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		calm      = 1'b0;
		stall_req = 1'b0;
		sim_now   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: exact period is not yet an emission, fill to full, retire
		send_tick('0, 32'd0);
		send_tick(20'd10000, 32'd100);
		send_tick(20'd1, 32'd200);
		send_tick('1, 32'd300);
		send_tick('1, 32'd400);
		send_tick('1, 32'd500);
		send_tick('1, 32'd600);
		send_tick('0, 32'd200 + 32'd5000000 - 32'd1);
		send_tick('0, 32'd5000200);
		send_tick('0, 32'd5000300);
		// time wrapped behind every stamp
		send_tick('0, 32'd16);
		// later stamps expire while older ones stay young
		send_tick(20'd10001, 32'd1000);
		send_tick(20'd20000, 32'd3000);
		send_tick('0, 32'd2000);

		drain();
		write_register(ter_pkg::REG_PERIOD, '0);
		send_tick('1, 32'd4000);
		send_tick(20'd1, 32'd4001);
		drain();
		write_register(ter_pkg::REG_LIFETIME, '0);
		send_tick('0, 32'd4002);
		send_tick(20'd5, 32'd4003);
		set_registers('1, '1);
		send_tick('1, 32'd5000);
		send_tick('0, 32'd4002);

		sim_now = 32'd6000;
		run_phase(65, 32'd5000000, 24'd10000);
		run_phase(65, $urandom_range(1000, 200000), 24'd1);
		run_phase(65, '0, '0);
		run_phase(65, '1, '1);

		calm = 1'b1;
		run_phase(65, $urandom_range(0, 4000000), PERIOD_W'($urandom_range(1, 40000)));
		calm = 1'b0;

		life = $urandom_range(100000, 2000000);
		per  = PERIOD_W'($urandom_range(2000, 20000));
		set_registers(life, per);
		// hold the receiver and keep offering ticks until input stalls
		stall_req = 1'b1;
		repeat (12) random_tick(per);
		drain();
		repeat (60) random_tick(per);

		run_phase(65, $urandom, PERIOD_W'($urandom_range(1, 24'hFFFFFF)));
		run_phase(65, $urandom_range(100000, 2000000),
			PERIOD_W'($urandom_range(2000, 20000)));

		drain();
		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

/* timestamped_ring_expiry_emitter.f */
rtl/core/ter_pkg.sv
rtl/core/ter_cell.sv
rtl/core/ter_div.sv
rtl/core/timestamped_ring_expiry_emitter.sv
verif/ring_tick_checker.sv
verif/testbench.sv
